[rtl/core/wss_pkg.sv]
// Shared constants and types of the wavetable sound generator.
`default_nettype none
package wss_pkg;

  localparam int ROM_WORDS = 4096;
  localparam int REG_WORDS = 32;
  localparam int ROM_AW    = $clog2(ROM_WORDS);
  localparam int REG_AW    = $clog2(REG_WORDS);

  // only phase bits up to 27 ever reach the sample address
  localparam int PH_W  = 28;
  localparam int SUM_W = 11;
  localparam int MAG_W = SUM_W;
  localparam int PROD_W = MAG_W + 8 + 1;

  typedef enum logic [1:0] {
    REQ_BANK_ONE = 2'd0,
    REQ_BANK_TWO = 2'd1,
    REQ_ROM_LOAD = 2'd2,
    REQ_TICK     = 2'd3
  } req_t;

  localparam logic [REG_AW-1:0] SHOT_REG   = 5'h1d;
  localparam logic [3:0]        SHOT_SPLIT = 4'hc;
  localparam logic [8:0]        SHOT_SLOW  = 9'(3000 / 16);
  localparam logic [8:0]        SHOT_FAST  = 9'(8000 / 16);
  localparam logic [3:0]        SHOT_VOL   = 4'd8;
  localparam logic [7:0]        END_BYTE   = 8'hff;
  localparam logic [7:0]        GAIN_RESET = 8'd48;
  localparam logic [15:0]       CLAMP_MAX  = 16'd32767;
  localparam logic [1:0]        SHOT_VOICE = 2'd3;

  typedef struct packed {
    logic                    go;
    logic signed [SUM_W-1:0] sum;
  } scale_req_t;

endpackage
`default_nettype wire

[rtl/core/wss_scale.sv]
// Gain scaling and clamping of the mixed voice sum.
`default_nettype none
module wss_scale
  import wss_pkg::*;
(
  input  wire logic        clk,
  input  wire scale_req_t  req,
  input  wire logic [7:0]  gain,
  output logic [15:0]      sample
);

  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic              neg;
  logic [15:0]       clamped;

  assign mag = req.sum[SUM_W-1] ? MAG_W'(-req.sum) : MAG_W'(req.sum);

  // product register breaks the multiplier from the clamp
  always_ff @(posedge clk) begin
    if (req.go) begin
      prod <= {PROD_W'(mag) * PROD_W'(gain)} << 1;
      neg  <= req.sum[SUM_W-1];
    end
  end

  assign clamped = (prod > PROD_W'(CLAMP_MAX)) ? CLAMP_MAX : prod[15:0];
  assign sample  = neg ? 16'(-clamped) : clamped;

endmodule
`default_nettype wire

[rtl/core/wavetable_sound_with_oneshot_top.sv]
// Top level of the wavetable sound generator with one-shot voice.
// Items arrive on the s_ stream: tuser carries the request kind (bank-one write, bank-two
// write, sample ROM load, tick). Writes and ROM loads give no result. Once a tick is
// accepted, no further item is taken until its sample is in the output register: the
// four voices are issued one per cycle into a three-stage pipeline (phase memory read,
// phase update and ROM read, nibble times volume accumulate), after which the sum is
// scaled by the gain in a product register and clamped into m_tdata. The single read
// port of the sample ROM and of the phase memory set the one-voice-per-cycle pace. The
// next item is accepted while a sample still waits on m_tready; a further tick waits
// only at its final step. The ROM has no reset: a tick that reads an unwritten byte
// gives an undefined sample. mix_gain sits at APB addresses 0 to 3 (paddr[2] low).
`default_nettype none
module wavetable_sound_with_oneshot_top
  import wss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // stream in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [11:0] addr, [19:12] data, [23:20] zero
  input  wire logic [1:0]  s_tuser,   // [1:0] req_type
  // stream out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [15:0] sample
  // APB config
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_SCALE,
    ST_EMIT
  } state_t;

  state_t state;

  // ---------------------------------------------------------------- config
  logic [7:0] mix_gain;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {24'd0, mix_gain};

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_gain <= GAIN_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      mix_gain <= pwdata[7:0];
    end
  end

  // ---------------------------------------------------------------- input decode
  logic              in_acc;
  req_t              req;
  logic [ROM_AW-1:0] in_addr;
  logic [7:0]        in_data;
  logic              reg_hit;

  // no intake while in reset
  assign s_tready = (state == ST_IDLE) && !rst;
  assign in_acc   = s_tvalid && s_tready;
  assign req      = req_t'(s_tuser);
  assign in_addr  = s_tdata[11:0];
  assign in_data  = s_tdata[19:12];
  // offsets beyond the bank are dropped
  assign reg_hit  = (in_addr < ROM_AW'(REG_WORDS));

  // ---------------------------------------------------------------- pipeline regs
  logic [1:0]        cnt;
  logic              s1_valid;
  logic [1:0]        s1_voice;
  logic              s2_valid;
  logic [1:0]        s2_voice;
  logic              s2_active;
  logic              s2_lownib;
  logic [3:0]        s2_vol;
  logic              issue;

  assign issue = (state == ST_RUN);

  // ---------------------------------------------------------------- register banks
  logic [7:0] bank_one [REG_WORDS];
  logic [7:0] bank_two [REG_WORDS];
  logic [8:0] shot_freq;
  logic [3:0] shot_vol;
  logic       shot_playing;
  logic       shot_write;
  logic       shot_end;

  assign shot_write = in_acc && (req == REQ_BANK_TWO) && reg_hit
                      && (in_addr[REG_AW-1:0] == SHOT_REG);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_WORDS; i++) begin
        bank_one[i] <= 8'd0;
        bank_two[i] <= 8'd0;
      end
      shot_freq    <= 9'd0;
      shot_vol     <= 4'd0;
      shot_playing <= 1'b0;
    end else begin
      if (in_acc && reg_hit && (req == REQ_BANK_ONE)) begin
        bank_one[in_addr[REG_AW-1:0]] <= in_data;
      end
      if (in_acc && reg_hit && (req == REQ_BANK_TWO)) begin
        bank_two[in_addr[REG_AW-1:0]] <= in_data;
      end
      if (shot_write) begin
        shot_freq    <= (in_data[3:0] < SHOT_SPLIT) ? SHOT_SLOW : SHOT_FAST;
        shot_vol     <= SHOT_VOL;
        shot_playing <= (in_data[3:0] != 4'd0);
      end else if (shot_end) begin
        shot_playing <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- phase memory
  // 4 x PH_W, sync read; valid bits stand in for the zero reset and the one-shot restart
  logic [PH_W-1:0] phase_mem [4];
  logic [PH_W-1:0] phase_q;
  logic [3:0]      phase_vld;
  logic [PH_W-1:0] ph_cur;
  logic [PH_W-1:0] ph_new;
  logic [11:0]     v_freq;
  logic [3:0]      v_vol;
  logic [3:0]      v_wave;
  logic            v_active;
  logic [ROM_AW-1:0] rom_raddr;

  always_ff @(posedge clk) begin
    if (issue) begin
      phase_q <= phase_mem[cnt];
    end
    if (s1_valid && v_active) begin
      phase_mem[s1_voice] <= ph_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_vld <= 4'd0;
    end else if (shot_write) begin
      phase_vld[SHOT_VOICE] <= 1'b0;
    end else if (s1_valid && v_active) begin
      phase_vld[s1_voice] <= 1'b1;
    end
  end

  // voice parameters for the voice in stage one
  always_comb begin
    if (s1_voice == SHOT_VOICE) begin
      v_freq = {3'd0, shot_freq};
      v_vol  = shot_vol;
      v_wave = 4'd0;
    end else begin
      v_freq = {bank_one[{s1_voice, 3'd2}][3:0], bank_one[{s1_voice, 3'd1}][3:0],
                bank_one[{s1_voice, 3'd0}][3:0]};
      v_vol  = bank_two[{s1_voice, 3'd6}][3:0];
      v_wave = bank_one[{s1_voice, 3'd6}][3:0];
    end
  end

  assign v_active = (v_freq != 12'd0) && (v_vol != 4'd0);
  assign ph_cur   = phase_vld[s1_voice] ? phase_q : PH_W'(0);
  assign ph_new   = ph_cur + PH_W'({v_freq, 4'd0});

  always_comb begin
    if (s1_voice == SHOT_VOICE) begin
      rom_raddr = {bank_two[SHOT_REG][3:0], 8'd0} + ph_new[27:16];
    end else begin
      rom_raddr = {3'd0, v_wave, ph_new[20:16]};
    end
  end

  // ---------------------------------------------------------------- sample ROM
  logic [7:0] rom_mem [ROM_WORDS];
  logic [7:0] rom_q;

  always_ff @(posedge clk) begin
    if (in_acc && (req == REQ_ROM_LOAD)) begin
      rom_mem[in_addr] <= in_data;
    end
    if (s1_valid) begin
      rom_q <= rom_mem[rom_raddr];
    end
  end

  // ---------------------------------------------------------------- stage two: mix
  logic [3:0]              nib;
  logic signed [4:0]       nib_s;
  logic signed [9:0]       prod_v;
  logic                    sounds;
  logic signed [SUM_W-1:0] acc;

  assign nib    = s2_lownib ? rom_q[3:0] : rom_q[7:4];
  assign nib_s  = $signed({1'b0, nib}) - 5'sd8;
  assign prod_v = 10'(nib_s) * $signed({6'd0, s2_vol});
  // one-shot ends on the marker byte and stays silent from that tick on until its register is written again
  assign shot_end = s2_valid && s2_active && (s2_voice == SHOT_VOICE) && (rom_q == END_BYTE);
  assign sounds = s2_active && ((s2_voice != SHOT_VOICE) || (shot_playing && !shot_end));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
    s1_voice  <= cnt;
    s2_voice  <= s1_voice;
    s2_active <= v_active;
    s2_lownib <= ph_new[15];
    s2_vol    <= v_vol;
    if (in_acc && (req == REQ_TICK)) begin
      acc <= '0;
    end else if (s2_valid && sounds) begin
      acc <= acc + SUM_W'(prod_v);
    end
  end

  // ---------------------------------------------------------------- scaler
  scale_req_t  sreq;
  logic [15:0] scaled;

  assign sreq.go  = (state == ST_SCALE);
  assign sreq.sum = acc;

  wss_scale u_scale (
    .clk    (clk),
    .req    (sreq),
    .gain   (mix_gain),
    .sample (scaled)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= 2'd0;
      m_tvalid <= 1'b0;
    end else begin
      // in ST_EMIT the output register is handled by the state itself
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          cnt <= 2'd0;
          if (in_acc && (req == REQ_TICK)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          cnt <= cnt + 2'd1;
          if (cnt == SHOT_VOICE) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (s2_valid && (s2_voice == SHOT_VOICE)) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= scaled;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- assertions
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!s1_valid && !s2_valid))
    else $error("pipeline busy while accepting items");

  a_tick_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (s_tuser == REQ_TICK)) |=> !s_tready)
    else $error("tick did not stop intake");

  a_pipe_flow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> (s2_valid && (s2_voice == $past(s1_voice))))
    else $error("voice lost between stages");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata != 16'h8000))
    else $error("sample outside clamp range");

endmodule
`default_nettype wire
